/* hw/rtl/rlpd_pkg.sv */
// Shared types and constants of the RLP stream decoder.
// Used by the classifier, the queue, the parser, the top level and the bench.
package rlpd_pkg;

   localparam int MaxDepthDefault = 16;
   localparam int LenBitsDefault  = 32;
   localparam int PosBits         = 64;
   localparam int QueueDepth      = 4;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NONCANON  = 3'd1;
   localparam logic [2:0] ERR_LEAD_ZERO = 3'd2;
   localparam logic [2:0] ERR_SHORT_LL  = 3'd3;
   localparam logic [2:0] ERR_OVERRUN   = 3'd4;
   localparam logic [2:0] ERR_TRUNC     = 3'd5;
   localparam logic [2:0] ERR_DEEP      = 3'd6;
   localparam logic [2:0] ERR_TOO_BIG   = 3'd7;

   typedef enum logic [2:0] {
      KIND_SINGLE,
      KIND_SHORT_STR,
      KIND_LONG_STR,
      KIND_SHORT_LIST,
      KIND_LONG_LIST
   } kind_type;

   // A classified byte: n is the short length or the count of length bytes.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      kind_type   kind;
      logic [5:0] n;
   } cls_type;

endpackage

/* hw/rtl/rlpd_if.sv */
// Valid/ready channel interfaces of the RLP stream decoder.
// Depends on nothing; the payload widths are fixed.
interface rlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, in_byte, in_last, input ready);
   modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface rlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       string_first;
   logic       string_last;
   logic [4:0] nest_level;
   logic       item_done;
   logic [2:0] fault_code;
   modport source (output valid, out_byte, byte_valid, string_first, string_last,
                   nest_level, item_done, fault_code, input ready);
   modport sink (input valid, out_byte, byte_valid, string_first, string_last,
                 nest_level, item_done, fault_code, output ready);
endinterface

/* hw/rtl/rlpd_front.sv */
// Front end: takes input bytes and classifies them by prefix range.
// Depends on rlpd_pkg and rlpd_req_if.
module rlpd_front
   import rlpd_pkg::*;
(
   rlpd_req_if.sink req_ch,
   input  logic     queue_full,
   output logic     push_valid,
   output cls_type  push_data
);

   logic [7:0] b;

   assign b = req_ch.in_byte;
   assign req_ch.ready = !queue_full;
   assign push_valid = req_ch.valid && !queue_full;

   always_comb begin
      push_data.data = b;
      push_data.last = req_ch.in_last;
      if (b <= 8'h7f) begin
         push_data.kind = KIND_SINGLE;
         push_data.n = 6'd0;
      end else if (b <= 8'hb7) begin
         push_data.kind = KIND_SHORT_STR;
         push_data.n = 6'(b - 8'h80);
      end else if (b <= 8'hbf) begin
         push_data.kind = KIND_LONG_STR;
         push_data.n = 6'(b - 8'hb7);
      end else if (b <= 8'hf7) begin
         push_data.kind = KIND_SHORT_LIST;
         push_data.n = 6'(b - 8'hc0);
      end else begin
         push_data.kind = KIND_LONG_LIST;
         push_data.n = 6'(b - 8'hf7);
      end
   end

endmodule

/* hw/rtl/rlpd_fifo.sv */
// Short queue of classified bytes between the front end and the parser.
// Depends on rlpd_pkg.
module rlpd_fifo
   import rlpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cls_type push_data,
   output logic    full,
   output logic    pop_valid,
   output cls_type pop_data,
   input  logic    pop
);

   localparam int PtrBits = $clog2(QueueDepth);

   cls_type              mem_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrBits:0]     count_ff, count_in;
   logic                 do_pop;

   assign full = count_ff == (PtrBits+1)'(QueueDepth);
   assign pop_valid = count_ff != '0;
   assign pop_data = mem_ff[rd_ff];
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_in = push_valid ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PtrBits+1)'(push_valid) - (PtrBits+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/rlpd_back.sv */
// Parser: header and payload state machine, list end stack, output register.
// Depends on rlpd_pkg and rlpd_rsp_if.
module rlpd_back
   import rlpd_pkg::*;
#(
   parameter int MAX_DEPTH = MaxDepthDefault,
   parameter int LEN_BITS  = LenBitsDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  cls_type  in_data,
   output logic     in_pop,
   rlpd_rsp_if.source rsp_ch
);

   localparam int SpBits  = $clog2(MAX_DEPTH + 1);
   localparam int IdxBits = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   typedef enum logic [1:0] {M_PREFIX, M_LENGTH, M_PAYLOAD, M_CHECK} mode_type;

   // Lists that end at the same position share one stack entry with a count.
   typedef struct packed {
      logic [PosBits-1:0] end_pos;
      logic [SpBits-1:0]  cnt;
   } entry_type;

   entry_type            stack_ff [MAX_DEPTH];
   entry_type            top_ff, top_in, wr_entry;
   logic [IdxBits-1:0]   wr_idx;
   logic                 wr_en;

   mode_type             mode_ff, mode_in;
   logic [3:0]           left_ff, left_in;
   logic [LEN_BITS-1:0]  accum_ff, accum_in, accum_new;
   logic                 is_list_ff, is_list_in;
   logic [PosBits-1:0]   npos_ff, npos_in, str_end_ff, str_end_in;
   logic [PosBits-1:0]   end_short, end_long;
   logic [SpBits-1:0]    sp_ff, sp_in, dsp_ff, dsp_in, sp_fin;
   logic                 hold_ff, hold_in, begun_ff, begun_in;

   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 bv_ff, bv_in, first_ff, first_in, lastb_ff, lastb_in;
   logic [4:0]           nest_ff, nest_in, nest_now;
   logic                 done_ff, done_in;
   logic [2:0]           err_ff, err_in;

   logic                 go, in_list, hit, done_fin, emit;
   logic [7:0]           b;
   logic [2:0]           err;

   assign go = in_valid && (!out_valid_ff || rsp_ch.ready);
   assign in_pop = go;
   assign b = in_data.data;
   assign in_list = sp_ff != '0;
   assign hit = in_list && top_ff.end_pos == npos_ff;
   assign sp_fin = hit ? sp_ff - top_ff.cnt : sp_ff;
   assign done_fin = sp_fin == '0;
   assign nest_now = (int'(sp_ff) > 31) ? 5'd31 : 5'(sp_ff);
   assign accum_new = {accum_ff[LEN_BITS-9:0], b};
   assign end_short = npos_ff + PosBits'(in_data.n);
   assign end_long = npos_ff + PosBits'(accum_new);

   always_comb begin
      mode_in = mode_ff;
      left_in = left_ff;
      accum_in = accum_ff;
      is_list_in = is_list_ff;
      npos_in = npos_ff;
      str_end_in = str_end_ff;
      sp_in = sp_ff;
      dsp_in = dsp_ff;
      top_in = top_ff;
      hold_in = hold_ff;
      begun_in = begun_ff;
      wr_en = 1'b0;
      wr_idx = IdxBits'(dsp_ff - 1'b1);
      wr_entry = top_ff;
      emit = 1'b0;
      err = ERR_NONE;
      out_byte_in = 8'd0;
      bv_in = 1'b0;
      first_in = 1'b0;
      lastb_in = 1'b0;
      nest_in = 5'd0;
      done_in = 1'b0;

      if (go && hold_ff) begin
         if (in_data.last) begin
            hold_in = 1'b0;
         end
      end else if (go) begin
         npos_in = npos_ff + 1'b1;
         if (mode_ff == M_CHECK && b <= 8'h7f) begin
            err = ERR_NONCANON;
         end else if (mode_ff == M_CHECK || mode_ff == M_PAYLOAD) begin
            emit = 1'b1;
            out_byte_in = b;
            bv_in = 1'b1;
            nest_in = nest_now;
            first_in = !begun_ff;
            begun_in = 1'b1;
            if (npos_ff == str_end_ff) begin
               lastb_in = 1'b1;
               mode_in = M_PREFIX;
               done_in = done_fin;
               sp_in = sp_fin;
            end else begin
               mode_in = M_PAYLOAD;
            end
         end else if (mode_ff == M_LENGTH) begin
            if (accum_ff[LEN_BITS-1:LEN_BITS-8] != 8'd0) begin
               err = ERR_TOO_BIG;
            end else if (accum_ff == '0 && b == 8'd0 && left_ff >= 4'd2) begin
               err = ERR_LEAD_ZERO;
            end else begin
               accum_in = accum_new;
               left_in = left_ff - 1'b1;
               if (left_ff == 4'd1) begin
                  mode_in = M_PREFIX;
                  if (end_long < npos_ff) begin
                     err = ERR_TOO_BIG;
                  end else if (is_list_ff && accum_new < LEN_BITS'(56)) begin
                     err = ERR_SHORT_LL;
                  end else if (in_list && end_long > top_ff.end_pos) begin
                     err = ERR_OVERRUN;
                  end else if (is_list_ff) begin
                     if (int'(sp_ff) >= MAX_DEPTH) begin
                        err = ERR_DEEP;
                     end else begin
                        sp_in = sp_ff + 1'b1;
                        if (in_list && top_ff.end_pos == end_long) begin
                           top_in.cnt = top_ff.cnt + 1'b1;
                        end else begin
                           wr_en = dsp_ff != '0;
                           top_in.end_pos = end_long;
                           top_in.cnt = SpBits'(1);
                           dsp_in = dsp_ff + 1'b1;
                        end
                     end
                  end else if (accum_new == '0) begin
                     emit = 1'b1;
                     first_in = 1'b1;
                     lastb_in = 1'b1;
                     nest_in = nest_now;
                     done_in = done_fin;
                     sp_in = sp_fin;
                  end else begin
                     str_end_in = end_long;
                     mode_in = M_PAYLOAD;
                     begun_in = 1'b0;
                  end
               end
            end
         end else begin
            case (in_data.kind)
               KIND_SINGLE: begin
                  emit = 1'b1;
                  out_byte_in = b;
                  bv_in = 1'b1;
                  first_in = 1'b1;
                  lastb_in = 1'b1;
                  nest_in = nest_now;
                  done_in = done_fin;
                  sp_in = sp_fin;
               end
               KIND_SHORT_STR: begin
                  if (in_data.n == 6'd0) begin
                     emit = 1'b1;
                     first_in = 1'b1;
                     lastb_in = 1'b1;
                     nest_in = nest_now;
                     done_in = done_fin;
                     sp_in = sp_fin;
                  end else if (in_list && end_short > top_ff.end_pos) begin
                     err = ERR_OVERRUN;
                  end else begin
                     str_end_in = end_short;
                     mode_in = (in_data.n == 6'd1) ? M_CHECK : M_PAYLOAD;
                     begun_in = 1'b0;
                  end
               end
               KIND_LONG_STR, KIND_LONG_LIST: begin
                  if (in_list && end_short > top_ff.end_pos) begin
                     err = ERR_OVERRUN;
                  end else begin
                     mode_in = M_LENGTH;
                     left_in = 4'(in_data.n);
                     accum_in = '0;
                     is_list_in = in_data.kind == KIND_LONG_LIST;
                  end
               end
               KIND_SHORT_LIST: begin
                  if (in_data.n == 6'd0) begin
                     // An empty list inside a list reads as an empty string.
                     if (in_list) begin
                        first_in = 1'b1;
                        lastb_in = 1'b1;
                        nest_in = nest_now;
                     end
                     done_in = done_fin;
                     sp_in = sp_fin;
                     emit = in_list || done_fin;
                  end else if (in_list && end_short > top_ff.end_pos) begin
                     err = ERR_OVERRUN;
                  end else if (int'(sp_ff) >= MAX_DEPTH) begin
                     err = ERR_DEEP;
                  end else begin
                     sp_in = sp_ff + 1'b1;
                     if (in_list && top_ff.end_pos == end_short) begin
                        top_in.cnt = top_ff.cnt + 1'b1;
                     end else begin
                        wr_en = dsp_ff != '0;
                        top_in.end_pos = end_short;
                        top_in.cnt = SpBits'(1);
                        dsp_in = dsp_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  err = ERR_NONE;
               end
            endcase
         end

         // A popped stack entry exposes the one below it as the new top.
         if (sp_in == sp_fin && hit && sp_in != sp_ff) begin
            dsp_in = dsp_ff - 1'b1;
            top_in = stack_ff[IdxBits'(dsp_ff - SpBits'(2))];
         end

         if (err == ERR_NONE && in_data.last && (mode_in != M_PREFIX || sp_in != '0)) begin
            err = ERR_TRUNC;
         end
         if (err != ERR_NONE) begin
            emit = 1'b1;
            out_byte_in = 8'd0;
            bv_in = 1'b0;
            first_in = 1'b0;
            lastb_in = 1'b0;
            nest_in = 5'd0;
            done_in = 1'b0;
            hold_in = !in_data.last;
         end
         if (err != ERR_NONE || in_data.last) begin
            mode_in = M_PREFIX;
            left_in = 4'd0;
            accum_in = '0;
            is_list_in = 1'b0;
            npos_in = PosBits'(1);
            str_end_in = '0;
            sp_in = '0;
            dsp_in = '0;
            begun_in = 1'b0;
         end
      end

      err_in = err;
      if (go) begin
         out_valid_in = emit;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_idx] <= wr_entry;
      end
      top_ff <= top_in;
      accum_ff <= accum_in;
      str_end_ff <= str_end_in;
      if (go && emit) begin
         out_byte_ff <= out_byte_in;
         bv_ff <= bv_in;
         first_ff <= first_in;
         lastb_ff <= lastb_in;
         nest_ff <= nest_in;
         done_ff <= done_in;
         err_ff <= err_in;
      end
      if (reset) begin
         mode_ff <= M_PREFIX;
         left_ff <= 4'd0;
         is_list_ff <= 1'b0;
         npos_ff <= PosBits'(1);
         sp_ff <= '0;
         dsp_ff <= '0;
         hold_ff <= 1'b0;
         begun_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         left_ff <= left_in;
         is_list_ff <= is_list_in;
         npos_ff <= npos_in;
         sp_ff <= sp_in;
         dsp_ff <= dsp_in;
         hold_ff <= hold_in;
         begun_ff <= begun_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.byte_valid = bv_ff;
   assign rsp_ch.string_first = first_ff;
   assign rsp_ch.string_last = lastb_ff;
   assign rsp_ch.nest_level = nest_ff;
   assign rsp_ch.item_done = done_ff;
   assign rsp_ch.fault_code = err_ff;

endmodule

/* hw/rtl/rlp_stream_decoder.sv */
// Streaming RLP decoder top level: classifier, byte queue and parser.
// Depends on rlpd_pkg, rlpd_if, rlpd_front, rlpd_fifo and rlpd_back.
//
// Usage: encoded bytes enter on req_ch, one per handshake, with in_last on the
// final byte of a buffer. String payloads leave on rsp_ch as a flat sequence of
// items: one per payload byte, one marker per empty string, one item_done
// item for an empty top-level list, and one item per fault with only the
// error code set. Header bytes produce no item unless they end an item or fault.
// After a fault, input is dropped up to and including the next in_last byte.
// Throughput is one byte per cycle while rsp_ch takes items. An input byte is
// written into the queue and then reaches the output register through the
// parser; the parser's state update per byte sets the rate.
// When rsp_ch stalls, the output register holds its item and the four-entry
// queue keeps taking bytes until it fills; then req_ch.ready drops.
// Synchronous reset empties the queue, drops the output item and returns the
// parser to the start of a buffer with an empty list stack.
module rlp_stream_decoder
   import rlpd_pkg::*;
#(
   parameter int MAX_DEPTH = MaxDepthDefault,
   parameter int LEN_BITS  = LenBitsDefault
) (
   input logic        clock,
   input logic        reset,
   rlpd_req_if.sink   req_ch,
   rlpd_rsp_if.source rsp_ch
);

   logic    push_valid, queue_full, pop_valid, pop;
   cls_type push_data, pop_data;

   rlpd_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rlpd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   rlpd_back #(
      .MAX_DEPTH (MAX_DEPTH),
      .LEN_BITS  (LEN_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pop_valid),
      .in_data  (pop_data),
      .in_pop   (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the streaming RLP decoder: directed buffers, then random buffers.
// Depends on rlpd_pkg, the rlpd_req_if/rlpd_rsp_if channels and rlp_stream_decoder.
module tb_top
   import rlpd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth   = MaxDepthDefault;
   localparam int LenBits = LenBitsDefault;
   localparam int StallLimit = 3000;

   typedef enum int {PM_PREFIX, PM_LENGTH, PM_PAYLOAD, PM_CHECK} parse_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_first;
      logic       string_last;
      logic [4:0] nest_level;
      logic       item_done;
      logic [2:0] fault_code;
   } rsp_type;

   class decoder_scoreboard;
      parse_mode_type mode;
      int          len_left;
      logic [63:0] len_acc, pos, str_end;
      logic [63:0] ends [Depth];
      int          sp;
      bit          hdr_list, discarding, begun;
      rsp_type     expected [$];
      int          mismatches;

      function void restart();
         mode = PM_PREFIX; len_left = 0; len_acc = 0; hdr_list = 0;
         pos = 0; str_end = 0; sp = 0; begun = 0;
      endfunction

      function new();
         restart();
         discarding = 0;
         mismatches = 0;
      endfunction

      // Closes every list that ends right before position e.
      function bit close_at(logic [63:0] e);
         while (sp > 0 && ends[sp-1] == e) sp--;
         return sp == 0;
      endfunction

      function logic [2:0] open_list(logic [63:0] e);
         if (sp >= Depth) return ERR_DEEP;
         ends[sp] = e;
         sp++;
         return ERR_NONE;
      endfunction

      function void note_byte(logic [7:0] b, bit last);
         rsp_type r;
         bit emit, in_list;
         logic [63:0] p, lim, e;
         int n;
         r = '0; emit = 0;
         if (discarding) begin
            if (last) begin
               restart();
               discarding = 0;
            end
            return;
         end
         p = pos; pos = p + 1;
         in_list = sp > 0;
         lim = in_list ? ends[sp-1] : 64'd0;
         if (mode == PM_CHECK && b <= 8'h7f) begin
            r.fault_code = ERR_NONCANON;
         end else if (mode == PM_CHECK || mode == PM_PAYLOAD) begin
            emit = 1;
            r.out_byte = b; r.byte_valid = 1;
            r.nest_level = sp > 31 ? 5'd31 : 5'(sp);
            r.string_first = !begun;
            begun = 1;
            if (p + 1 == str_end) begin
               r.string_last = 1;
               mode = PM_PREFIX;
               r.item_done = close_at(p + 1);
            end else begin
               mode = PM_PAYLOAD;
            end
         end else if (mode == PM_LENGTH) begin
            if ((len_acc >> (LenBits - 8)) != 0) begin
               r.fault_code = ERR_TOO_BIG;
            end else if (len_acc == 0 && b == 0 && len_left >= 2) begin
               r.fault_code = ERR_LEAD_ZERO;
            end else begin
               len_acc = (len_acc << 8) | 64'(b);
               if (len_left > 0) len_left--;
               if (len_left == 0) begin
                  e = p + 1 + len_acc;
                  mode = PM_PREFIX;
                  if (e < p + 1) r.fault_code = ERR_TOO_BIG;
                  else if (hdr_list && len_acc < 56) r.fault_code = ERR_SHORT_LL;
                  else if (in_list && e > lim) r.fault_code = ERR_OVERRUN;
                  else if (hdr_list) r.fault_code = open_list(e);
                  else if (len_acc == 0) begin
                     emit = 1; r.string_first = 1; r.string_last = 1;
                     r.nest_level = sp > 31 ? 5'd31 : 5'(sp);
                     r.item_done = close_at(p + 1);
                  end else begin
                     str_end = e; mode = PM_PAYLOAD; begun = 0;
                  end
               end
            end
         end else if (b <= 8'h7f) begin
            emit = 1;
            r.out_byte = b; r.byte_valid = 1; r.string_first = 1; r.string_last = 1;
            r.nest_level = sp > 31 ? 5'd31 : 5'(sp);
            r.item_done = close_at(p + 1);
         end else if (b <= 8'hb7) begin
            n = b - 8'h80;
            if (n == 0) begin
               emit = 1; r.string_first = 1; r.string_last = 1;
               r.nest_level = sp > 31 ? 5'd31 : 5'(sp);
               r.item_done = close_at(p + 1);
            end else if (in_list && p + 1 + n > lim) begin
               r.fault_code = ERR_OVERRUN;
            end else begin
               str_end = p + 1 + n;
               mode = (n == 1) ? PM_CHECK : PM_PAYLOAD;
               begun = 0;
            end
         end else if (b <= 8'hbf || b >= 8'hf8) begin
            n = (b <= 8'hbf) ? b - 8'hb7 : b - 8'hf7;
            if (in_list && p + 1 + n > lim) begin
               r.fault_code = ERR_OVERRUN;
            end else begin
               mode = PM_LENGTH; len_left = n; len_acc = 0; hdr_list = b >= 8'hf8;
            end
         end else begin
            n = b - 8'hc0;
            if (n == 0) begin
               // An empty list inside a list reads as an empty string.
               if (in_list) begin
                  emit = 1; r.string_first = 1; r.string_last = 1;
                  r.nest_level = sp > 31 ? 5'd31 : 5'(sp);
               end
               r.item_done = close_at(p + 1);
               if (r.item_done) emit = 1;
            end else if (in_list && p + 1 + n > lim) begin
               r.fault_code = ERR_OVERRUN;
            end else begin
               r.fault_code = open_list(p + 1 + n);
            end
         end
         if (r.fault_code == ERR_NONE && last && (mode != PM_PREFIX || sp != 0))
            r.fault_code = ERR_TRUNC;
         if (r.fault_code != ERR_NONE) begin
            emit = 1;
            r = '{fault_code: r.fault_code, default: '0};
            restart();
            if (!last) discarding = 1;
         end else if (last) begin
            restart();
         end
         if (emit) expected.insert(expected.size(), r);
      endfunction

      function void check(rsp_type got);
         rsp_type w;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %p", got);
            return;
         end
         w = expected.pop_front();
         if (got.out_byte != w.out_byte || got.byte_valid != w.byte_valid ||
             got.string_first != w.string_first || got.string_last != w.string_last ||
             got.nest_level != w.nest_level || got.item_done != w.item_done ||
             got.fault_code != w.fault_code) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", w, got);
         end
      endfunction
   endclass

   logic clock, reset;
   rlpd_req_if req_ch ();
   rlpd_rsp_if rsp_ch ();

   rlp_stream_decoder DUT (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   decoder_scoreboard sb = new();
   bit quiet = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Result side: random stall bursts and one long hold-off on request.
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 9);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check('{rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.string_first,
                    rsp_ch.string_last, rsp_ch.nest_level, rsp_ch.item_done,
                    rsp_ch.fault_code});
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b, bit last);
      int n;
      if (!quiet && $urandom_range(0, 6) == 0) begin
         req_ch.valid <= 1'b0;
         n = $urandom_range(1, 9);
         repeat (n) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_byte(b, last);
   endtask

   task automatic send_buffer(logic [7:0] q [$]);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   function automatic void add_string(ref logic [7:0] q [$]);
      int n;
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            b = 8'($urandom_range(0, 255));
            if (b <= 8'h7f && $urandom_range(0, 1)) q.insert(q.size(), b);
            else begin
               q.insert(q.size(), 8'h81);
               q.insert(q.size(), b | 8'h80);
            end
         end
         3: begin
            n = $urandom_range(56, 80);
            q.insert(q.size(), 8'hb8);
            q.insert(q.size(), 8'(n));
            repeat (n) q.insert(q.size(), 8'($urandom_range(0, 255)));
         end
         4: begin
            // Long form with a short length is accepted for strings.
            n = $urandom_range(0, 4);
            q.insert(q.size(), 8'hb8);
            q.insert(q.size(), 8'(n));
            repeat (n) q.insert(q.size(), 8'($urandom_range(0, 255)));
         end
         default: begin
            n = $urandom_range(0, 6);
            if (n == 1) n = 2;
            q.insert(q.size(), 8'(8'h80 + n));
            repeat (n) q.insert(q.size(), 8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   function automatic void add_element(ref logic [7:0] q [$], input int depth);
      logic [7:0] body [$];
      int kids;
      if (depth < 4 && $urandom_range(0, 2) == 0) begin
         kids = $urandom_range(0, 4);
         repeat (kids) add_element(body, depth + 1);
         if (body.size() >= 56) begin
            if (body.size() > 255) begin
               q.insert(q.size(), 8'hf9);
               q.insert(q.size(), 8'(body.size() >> 8));
            end else begin
               q.insert(q.size(), 8'hf8);
            end
            q.insert(q.size(), 8'(body.size()));
         end else begin
            q.insert(q.size(), 8'(8'hc0 + body.size()));
         end
         foreach (body[i]) q.insert(q.size(), body[i]);
      end else begin
         add_string(q);
      end
   endfunction

   initial begin
      logic [7:0] q [$];
      int sent, k;
      bit held_once;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= 8'h00;
      req_ch.in_last <= 1'b0;
      reset = 1'b1;
      held_once = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_buffer('{8'h00});
      send_buffer('{8'h7f, 8'h80, 8'hc0});
      send_buffer('{8'h81, 8'h05});                       // noncanonical single byte
      send_buffer('{8'h81, 8'hff});
      send_buffer('{8'hb8, 8'h00});                       // long form, empty
      send_buffer('{8'hb9, 8'h00, 8'h05, 8'h11});         // leading zero length
      send_buffer('{8'hf8, 8'h05, 8'h01, 8'h02});         // long list under 56
      send_buffer('{8'hc2, 8'hc0, 8'h80});
      send_buffer('{8'hc2, 8'h83, 8'h01, 8'h02, 8'h03});  // element overruns list
      send_buffer('{8'hc3, 8'h01, 8'h02});                // truncated list
      send_buffer('{8'hbc, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}); // too big
      q = {};
      for (int i = 0; i < 17; i++) q.insert(q.size(), 8'(8'hc0 + 17 - i));
      q.insert(q.size(), 8'h80);
      send_buffer(q);                                      // nesting too deep

      sent = 0;
      while (sent < 1800) begin
         q = {};
         k = $urandom_range(1, 3);
         repeat (k) add_element(q, 0);
         case ($urandom_range(0, 11))
            0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
            1: if (q.size() > 1) q = q[0:$urandom_range(0, q.size() - 2)];
            2: repeat ($urandom_range(1, 6)) q.insert(q.size(), 8'($urandom_range(0, 255)));
            default: ;
         endcase
         if (sent > 300 && !held_once) begin
            hold_rsp = 1;
            held_once = 1;
         end
         if (sent > 1500) quiet = 1;
         send_buffer(q);
         sent += q.size();
      end
      req_ch.valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
